// ----- hw/rtl/bls_pkg.sv -----
package bls_pkg;

	// screen defaults
	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 512;

	// command queue between classifier and walker
	localparam int QUEUE_DEPTH = 2;

	// field widths
	localparam int COORD_W = 12;
	localparam int TERM_W  = 16;
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 19;

	// stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 80;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		OCT_STEEP_RISE   = 2'd0,
		OCT_SHALLOW_RISE = 2'd1,
		OCT_STEEP_FALL   = 2'd2,
		OCT_SHALLOW_FALL = 2'd3
	} oct_t;

	// classified request, as queued for the walker
	typedef struct packed {
		req_t                      kind;
		logic [COORD_W-1:0]        x;
		logic [COORD_W-1:0]        y;
		logic [COORD_W-1:0]        stop;
		logic signed [TERM_W-1:0]  dterm;
		logic signed [TERM_W-1:0]  inc_s;
		logic signed [TERM_W-1:0]  inc_d;
		oct_t                      oct;
		logic [COLOR_W-1:0]        color;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- hw/rtl/bls_front.sv -----
// Request classifier: orders endpoints, picks the octant case and
// computes the Bresenham terms for a start beat.
module bls_front (
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [bls_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic [0:0]                         s_axis_tuser,
	input  bls_pkg::q_stat_t                   q_stat,
	output logic                               push,
	output bls_pkg::cmd_t                      cmd
);

	logic signed [11:0] sx_in, sy_in, ex_in, ey_in;
	logic signed [11:0] sx, sy, ex, ey;
	logic               swap;
	logic signed [15:0] dx, dy, ady, major, minor;
	logic               rise, steep;
	bls_pkg::oct_t      oct;

	assign sx_in = s_axis_tdata[11:0];
	assign sy_in = s_axis_tdata[23:12];
	assign ex_in = s_axis_tdata[35:24];
	assign ey_in = s_axis_tdata[47:36];

	assign swap = ex_in < sx_in;

	always_comb begin
		if (swap) begin
			sx = ex_in;
			sy = ey_in;
			ex = sx_in;
			ey = sy_in;
		end else begin
			sx = sx_in;
			sy = sy_in;
			ex = ex_in;
			ey = ey_in;
		end
	end

	assign dx  = 16'(ex) - 16'(sx);
	assign dy  = 16'(ey) - 16'(sy);
	assign ady = -dy;

	assign rise  = dy > 16'sd0;
	assign steep = rise ? (dy > dx) : (ady > dx);

	always_comb begin
		if (rise) begin
			oct = steep ? bls_pkg::OCT_STEEP_RISE : bls_pkg::OCT_SHALLOW_RISE;
		end else begin
			oct = steep ? bls_pkg::OCT_STEEP_FALL : bls_pkg::OCT_SHALLOW_FALL;
		end
	end

	always_comb begin
		case (oct)
			bls_pkg::OCT_STEEP_RISE: begin
				major = dy;
				minor = dx;
			end
			bls_pkg::OCT_SHALLOW_RISE: begin
				major = dx;
				minor = dy;
			end
			bls_pkg::OCT_STEEP_FALL: begin
				major = ady;
				minor = dx;
			end
			default: begin
				major = dx;
				minor = ady;
			end
		endcase
	end

	always_comb begin
		cmd.kind  = bls_pkg::req_t'(s_axis_tuser[0]);
		cmd.x     = sx;
		cmd.y     = sy;
		cmd.stop  = steep ? ey : ex;
		cmd.dterm = (minor <<< 1) - major;
		cmd.inc_s = minor <<< 1;
		cmd.inc_d = (minor <<< 1) - (major <<< 1);
		cmd.oct   = oct;
		cmd.color = s_axis_tdata[79:48];
	end

	assign s_axis_tready = !q_stat.full;
	assign push          = s_axis_tvalid && !q_stat.full;

endmodule

// ----- hw/rtl/bls_queue.sv -----
// Short command FIFO; push and pop may happen in the same cycle.
module bls_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bls_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output bls_pkg::cmd_t     head,
	output bls_pkg::q_stat_t  q_stat
);

	localparam int PTR_W = (bls_pkg::QUEUE_DEPTH > 1) ? $clog2(bls_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(bls_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bls_pkg::QUEUE_DEPTH - 1);

	bls_pkg::cmd_t     mem_q [bls_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = count_q == CNT_W'(bls_pkg::QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;

endmodule

// ----- hw/rtl/bls_walker.sv -----
// Line walker: holds the active line, emits one pixel per step command
// into the output register while a line is active.
module bls_walker #(
	parameter int SCREEN_WIDTH  = bls_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bls_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bls_pkg::cmd_t                    head,
	input  bls_pkg::q_stat_t                 q_stat,
	output logic                             pop,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [0:0]                       m_axis_tuser,
	output logic                             m_axis_tlast
);

	localparam int PROD_W = 23;

	// line state
	logic [11:0]        cur_x_q, cur_y_q, stop_q;
	logic signed [15:0] dterm_q, inc_s_q, inc_d_q;
	bls_pkg::oct_t      oct_q;
	logic [31:0]        color_q;
	logic               active_q;

	// output register
	logic               out_valid_q;
	logic [11:0]        out_x_q, out_y_q;
	logic [18:0]        out_addr_q;
	logic               out_vis_q, out_last_q;
	logic [31:0]        out_color_q;

	logic               out_free, is_step, emit, steep, diag, last, vis;
	logic [PROD_W-1:0]  prod;
	logic [18:0]        addr;

	assign out_free = !out_valid_q || m_axis_tready;
	assign pop      = !q_stat.empty && out_free;
	assign is_step  = head.kind == bls_pkg::REQ_STEP;
	assign emit     = pop && is_step && active_q;

	assign steep = (oct_q == bls_pkg::OCT_STEEP_RISE) || (oct_q == bls_pkg::OCT_STEEP_FALL);
	assign last  = (steep ? cur_y_q : cur_x_q) == stop_q;
	assign diag  = steep ? !dterm_q[15] : (!dterm_q[15] && (dterm_q != 16'sd0));

	assign vis = !cur_x_q[11] && ({2'b00, cur_x_q[10:0]} < 13'(SCREEN_WIDTH))
		&& !cur_y_q[11] && ({2'b00, cur_y_q[10:0]} < 13'(SCREEN_HEIGHT));

	assign prod = PROD_W'(cur_y_q[10:0]) * PROD_W'(SCREEN_WIDTH);
	assign addr = vis ? (prod[18:0] + 19'(cur_x_q[10:0])) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (pop) begin
				if (!is_step) begin
					active_q <= 1'b1;
				end else if (emit && last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !is_step) begin
			cur_x_q <= head.x;
			cur_y_q <= head.y;
			stop_q  <= head.stop;
			dterm_q <= head.dterm;
			inc_s_q <= head.inc_s;
			inc_d_q <= head.inc_d;
			oct_q   <= head.oct;
			color_q <= head.color;
		end else if (emit && !last) begin
			dterm_q <= dterm_q + (diag ? inc_d_q : inc_s_q);
			case (oct_q)
				bls_pkg::OCT_STEEP_RISE: begin
					cur_y_q <= cur_y_q + 1'b1;
					if (diag) cur_x_q <= cur_x_q + 1'b1;
				end
				bls_pkg::OCT_SHALLOW_RISE: begin
					cur_x_q <= cur_x_q + 1'b1;
					if (diag) cur_y_q <= cur_y_q + 1'b1;
				end
				bls_pkg::OCT_STEEP_FALL: begin
					cur_y_q <= cur_y_q - 1'b1;
					if (diag) cur_x_q <= cur_x_q + 1'b1;
				end
				default: begin
					cur_x_q <= cur_x_q + 1'b1;
					if (diag) cur_y_q <= cur_y_q - 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_x_q     <= cur_x_q;
			out_y_q     <= cur_y_q;
			out_addr_q  <= addr;
			out_vis_q   <= vis;
			out_color_q <= color_q;
			out_last_q  <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_color_q, out_addr_q, out_y_q, out_x_q};
	assign m_axis_tuser  = out_vis_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- hw/rtl/bresenham_line_stepper.sv -----
// Bresenham line stepper - one pixel beat per step request.
//
// Slave channel (s_axis_*): request beats. tuser = 0 loads a new line
// (two endpoints and a color, no output beat); tuser = 1 asks for the next
// pixel. A step with no line active is consumed and gives nothing.
// Master channel (m_axis_*): one pixel beat per step; tlast marks the
// final pixel of the line, tuser flags a pixel inside the screen window.
//
// Throughput: one beat per cycle on both sides while m_axis_tready is
// high. The classifier works on the incoming beat combinationally, a
// two-entry command queue decouples it from the walker, and the walker
// updates x/y and the decision term in its line state registers. A step
// beat goes into the queue, then its pixel into the output register.
//
// Stall: when m_axis_tready is low the pixel holds in the output register;
// the queue absorbs up to two more requests, then s_axis_tready drops.
// Reset (arst_n low): queue emptied, no line active, m_axis_tvalid low.
module bresenham_line_stepper #(
	parameter int SCREEN_WIDTH  = bls_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bls_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], line_color[79:48]
	input  logic [bls_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// req_type[0]
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pixel_x[11:0], pixel_y[23:12], pixel_address[42:24], pixel_color[74:43], zero pad
	output logic [bls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// visible[0]
	output logic [0:0]                       m_axis_tuser,
	// last_pixel
	output logic                             m_axis_tlast
);

	bls_pkg::cmd_t    push_cmd, head;
	bls_pkg::q_stat_t q_stat;
	logic             push, pop;

	// classify incoming beats and precompute line terms
	bls_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_stat        (q_stat),
		.push          (push),
		.cmd           (push_cmd)
	);

	// decoupling queue
	bls_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// line walk and output register
	bls_walker #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- hw/rtl/bls_checker.sv -----
module bls_checker #(
	parameter int SCREEN_WIDTH  = bls_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bls_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [bls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic [0:0]                       m_axis_tuser,
	input  logic                             m_axis_tlast
);

	logic signed [11:0] px, py;
	logic               in_window;

	assign px = m_axis_tdata[11:0];
	assign py = m_axis_tdata[23:12];
	assign in_window = (px >= 0) && (px < SCREEN_WIDTH) && (py >= 0) && (py < SCREEN_HEIGHT);

	// output register cleared by reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// stalled beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled pixel beat changed");

	// visible flag matches the screen window
	a_vis_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[0] == in_window)
		else $error("visible flag disagrees with pixel position");

	// clipped pixels carry a zero address
	a_clip_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[42:24] == 19'd0)
		else $error("clipped pixel has nonzero address");

endmodule

bind bresenham_line_stepper bls_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
